// ===== design/vpae_pkg.sv =====
// Shared types and constants for the video port access engine.
package vpae_pkg;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_FILL  = 6'b001000,
        ST_CPRD  = 6'b010000,
        ST_CPWR  = 6'b100000
    } vpae_state_t;

    localparam logic [1:0] OP_CTRL = 2'd0;
    localparam logic [1:0] OP_STAT = 2'd1;
    localparam logic [1:0] OP_DWR  = 2'd2;
    localparam logic [1:0] OP_DRD  = 2'd3;

    // Low nibble of the access code selects the target.
    localparam logic [3:0] CODE_VRAM_RD = 4'h0;
    localparam logic [3:0] CODE_VRAM_WR = 4'h1;
    localparam logic [3:0] CODE_CRAM_WR = 4'h3;
    localparam logic [3:0] CODE_VSRAM_RD = 4'h4;
    localparam logic [3:0] CODE_VSRAM_WR = 4'h5;
    localparam logic [3:0] CODE_CRAM_RD = 4'h8;

    localparam logic [1:0] DMA_MODE_FILL = 2'b10;
    localparam logic [1:0] DMA_MODE_COPY = 2'b11;
    localparam logic [1:0] CTRL_REG_WRITE = 2'b10;

    localparam logic [4:0] REG_MODE2   = 5'd1;
    localparam logic [4:0] REG_INCR    = 5'd15;
    localparam logic [4:0] REG_LEN_LO  = 5'd19;
    localparam logic [4:0] REG_LEN_HI  = 5'd20;
    localparam logic [4:0] REG_SRC_LO  = 5'd21;
    localparam logic [4:0] REG_SRC_HI  = 5'd22;
    localparam logic [4:0] REG_DMA     = 5'd23;

    localparam logic [15:0] STATUS_FIXED = 16'h4C00;
    localparam logic [9:0]  STATUS_MASK  = 10'h3BF;

endpackage

// ===== design/video_port_access_engine.sv =====
// Video port access engine: control/data port front end with VRAM fill and copy.
//
// Usage: drive op and word_in and pulse start while busy is low; that cycle
// is the accepted transaction. Each transaction gives exactly one result,
// shown on rdata for one cycle with done high. The receiver cannot stall.
// Control writes, status reads and data writes give their result the cycle
// after acceptance and, unless they start a fill or copy, the port is free
// again that same cycle. A data read does its synchronous memory read first
// and forms the word after it. A data write that triggers a fill keeps busy
// high until it has written N bytes (N = regs 20:19, zero meaning 65536). A
// control word that starts a copy keeps busy high while it reads each source
// byte and then writes it, over the same N bytes.
// Video RAM sits in two byte banks (even/odd address) of 32768 entries.
// After reset the block runs a clearing pass over both banks, one entry per
// cycle, with busy high, before the first transaction is taken.
// Colour and scroll RAMs use per-entry valid bits cleared at reset.
module video_port_access_engine
    import vpae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [15:0] word_in,
    output logic        done,
    output logic [15:0] rdata
);

    vpae_state_t state_reg, state_next;

    logic [15:0] addr_reg, addr_next;
    logic [1:0]  hi_latch_reg, hi_latch_next;
    logic [5:0]  code_reg, code_next;
    logic        pending_reg, pending_next;
    logic        fill_armed_reg, fill_armed_next;
    logic [9:0]  status_reg, status_next;
    logic [14:0] clr_cnt_reg, clr_cnt_next;
    logic [16:0] cnt_reg, cnt_next;
    logic [15:0] src_reg, src_next;
    logic [7:0]  fill_byte_reg, fill_byte_next;
    logic        done_reg, done_next;
    logic [15:0] rdata_reg, rdata_next;
    logic [63:0] col_vld_reg;
    logic [63:0] scr_vld_reg;

    logic [7:0]  regs_reg [32];

    // Memories
    logic [7:0]  vram_ev [32768];
    logic [7:0]  vram_od [32768];
    logic [8:0]  cram [64];
    logic [15:0] vsram [64];

    logic        ev_we, od_we, ev_re, od_re;
    logic [14:0] ev_waddr, od_waddr, ev_raddr, od_raddr;
    logic [7:0]  ev_wdata, od_wdata, ev_rdata, od_rdata;
    logic        col_we, col_re, scr_we, scr_re;
    logic [5:0]  col_waddr, col_raddr, scr_waddr, scr_raddr;
    logic [8:0]  col_wdata, col_rdata;
    logic [15:0] scr_wdata, scr_rdata;
    logic        col_rvld, scr_rvld;

    logic        rf_we, rf_len_clr;
    logic [4:0]  rf_waddr;
    logic [7:0]  rf_wdata;

    logic [15:0] addr_step;
    logic [16:0] dma_len;
    logic [15:0] w_store;
    logic [9:0]  stat_tmp;
    logic [8:0]  col_p;
    logic [7:0]  cp_byte;

    assign addr_step = addr_reg + {8'd0, regs_reg[REG_INCR]};
    assign dma_len   = {({regs_reg[REG_LEN_HI], regs_reg[REG_LEN_LO]} == 16'd0),
                        regs_reg[REG_LEN_HI], regs_reg[REG_LEN_LO]};
    assign stat_tmp  = ((status_reg & ~10'h020) | 10'h200) ^ 10'h004;
    assign col_p     = col_rvld ? col_rdata : 9'd0;
    assign cp_byte   = src_reg[0] ? od_rdata : ev_rdata;

    always_comb
    begin
        case (code_reg[3:0])
            CODE_VRAM_WR: w_store = addr_reg[0] ? {word_in[7:0], word_in[15:8]} : word_in;
            CODE_CRAM_WR: w_store = word_in & 16'h0EEE;
            default:      w_store = word_in;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        hi_latch_next   = hi_latch_reg;
        code_next       = code_reg;
        pending_next    = pending_reg;
        fill_armed_next = fill_armed_reg;
        status_next     = status_reg;
        clr_cnt_next    = clr_cnt_reg;
        cnt_next        = cnt_reg;
        src_next        = src_reg;
        fill_byte_next  = fill_byte_reg;
        done_next       = 1'b0;
        rdata_next      = rdata_reg;
        ev_we = 1'b0; od_we = 1'b0; ev_re = 1'b0; od_re = 1'b0;
        ev_waddr = addr_reg[15:1]; od_waddr = addr_reg[15:1];
        ev_raddr = addr_reg[15:1]; od_raddr = addr_reg[15:1];
        ev_wdata = 8'd0; od_wdata = 8'd0;
        col_we = 1'b0; col_re = 1'b0; scr_we = 1'b0; scr_re = 1'b0;
        col_waddr = addr_reg[6:1]; col_raddr = addr_reg[6:1];
        scr_waddr = addr_reg[6:1]; scr_raddr = addr_reg[6:1];
        col_wdata = {w_store[3:1], w_store[7:5], w_store[11:9]};
        scr_wdata = word_in;
        rf_we = 1'b0; rf_len_clr = 1'b0;
        rf_waddr = word_in[12:8];
        rf_wdata = word_in[7:0];

        case (state_reg)
            ST_CLEAR:
            begin
                ev_we = 1'b1; od_we = 1'b1;
                ev_waddr = clr_cnt_reg; od_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 15'd1;
                if (&clr_cnt_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    rdata_next = 16'd0;
                    case (op)
                        OP_CTRL:
                        begin
                            if (!pending_reg)
                            begin
                                if (word_in[15:14] == CTRL_REG_WRITE)
                                    rf_we = 1'b1;
                                else
                                    pending_next = 1'b1;
                                addr_next = {hi_latch_reg, word_in[13:0]};
                                code_next = {code_reg[5:2], word_in[15:14]};
                            end
                            else
                            begin
                                pending_next  = 1'b0;
                                addr_next     = {word_in[1:0], addr_reg[13:0]};
                                code_next     = {word_in[7:4], code_reg[1:0]};
                                hi_latch_next = word_in[1:0];
                                if (word_in[7] && regs_reg[REG_MODE2][4])
                                begin
                                    if (regs_reg[REG_DMA][7:6] == DMA_MODE_FILL)
                                        fill_armed_next = 1'b1;
                                    else if (regs_reg[REG_DMA][7:6] == DMA_MODE_COPY)
                                    begin
                                        cnt_next   = dma_len;
                                        src_next   = {regs_reg[REG_SRC_HI], regs_reg[REG_SRC_LO]};
                                        state_next = ST_CPRD;
                                    end
                                end
                            end
                        end
                        OP_STAT:
                        begin
                            pending_next   = 1'b0;
                            status_next    = stat_tmp;
                            rdata_next     = STATUS_FIXED | {6'd0, stat_tmp & STATUS_MASK};
                        end
                        OP_DWR:
                        begin
                            pending_next = 1'b0;
                            case (code_reg[3:0])
                                CODE_VRAM_WR:
                                begin
                                    ev_we = 1'b1; od_we = 1'b1;
                                    ev_wdata = w_store[15:8];
                                    od_wdata = w_store[7:0];
                                end
                                CODE_CRAM_WR:  col_we = 1'b1;
                                CODE_VSRAM_WR: scr_we = 1'b1;
                                default: ;
                            endcase
                            addr_next = addr_step;
                            if (fill_armed_reg)
                            begin
                                fill_armed_next = 1'b0;
                                fill_byte_next  = w_store[15:8];
                                cnt_next        = dma_len;
                                state_next      = ST_FILL;
                            end
                        end
                        default:
                        begin
                            pending_next = 1'b0;
                            done_next    = 1'b0;
                            ev_re = 1'b1; od_re = 1'b1;
                            col_re = 1'b1; scr_re = 1'b1;
                            addr_next  = addr_step;
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                done_next = 1'b1;
                case (code_reg[3:0])
                    CODE_VRAM_RD:  rdata_next = {ev_rdata, od_rdata};
                    CODE_CRAM_RD:  rdata_next = {4'd0, col_p[2:0], 1'b0, col_p[5:3],
                                                 1'b0, col_p[8:6], 1'b0};
                    CODE_VSRAM_RD: rdata_next = scr_rvld ? scr_rdata : 16'd0;
                    default:       rdata_next = 16'd0;
                endcase
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                ev_we = ~addr_reg[0]; od_we = addr_reg[0];
                ev_wdata = fill_byte_reg; od_wdata = fill_byte_reg;
                addr_next = addr_step;
                cnt_next  = cnt_reg - 17'd1;
                if (cnt_reg == 17'd1)
                    state_next = ST_IDLE;
            end
            ST_CPRD:
            begin
                ev_re = ~src_reg[0]; od_re = src_reg[0];
                ev_raddr = src_reg[15:1]; od_raddr = src_reg[15:1];
                state_next = ST_CPWR;
            end
            ST_CPWR:
            begin
                ev_we = ~addr_reg[0]; od_we = addr_reg[0];
                ev_wdata = cp_byte; od_wdata = cp_byte;
                src_next  = src_reg + 16'd1;
                addr_next = addr_step;
                cnt_next  = cnt_reg - 17'd1;
                if (cnt_reg == 17'd1)
                begin
                    rf_len_clr = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_CPRD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            hi_latch_reg   <= '0;
            code_reg       <= '0;
            pending_reg    <= 1'b0;
            fill_armed_reg <= 1'b0;
            status_reg     <= '0;
            clr_cnt_reg    <= '0;
            cnt_reg        <= '0;
            src_reg        <= '0;
            done_reg       <= 1'b0;
            col_vld_reg    <= '0;
            scr_vld_reg    <= '0;
            for (int i = 0; i < 32; i++)
                regs_reg[5'(i)] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            hi_latch_reg   <= hi_latch_next;
            code_reg       <= code_next;
            pending_reg    <= pending_next;
            fill_armed_reg <= fill_armed_next;
            status_reg     <= status_next;
            clr_cnt_reg    <= clr_cnt_next;
            cnt_reg        <= cnt_next;
            src_reg        <= src_next;
            done_reg       <= done_next;
            if (col_we)
                col_vld_reg[col_waddr] <= 1'b1;
            if (scr_we)
                scr_vld_reg[scr_waddr] <= 1'b1;
            if (rf_we)
                regs_reg[rf_waddr] <= rf_wdata;
            if (rf_len_clr)
            begin
                regs_reg[REG_LEN_LO] <= '0;
                regs_reg[REG_LEN_HI] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_byte_reg <= fill_byte_next;
        rdata_reg     <= rdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (ev_we)
            vram_ev[ev_waddr] <= ev_wdata;
        if (ev_re)
            ev_rdata <= vram_ev[ev_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (od_we)
            vram_od[od_waddr] <= od_wdata;
        if (od_re)
            od_rdata <= vram_od[od_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            cram[col_waddr] <= col_wdata;
        if (col_re)
        begin
            col_rdata <= cram[col_raddr];
            col_rvld  <= col_vld_reg[col_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            vsram[scr_waddr] <= scr_wdata;
        if (scr_re)
        begin
            scr_rdata <= vsram[scr_raddr];
            scr_rvld  <= scr_vld_reg[scr_raddr];
        end
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign rdata = rdata_reg;

    a_read_enters: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_DRD |=> state_reg == ST_READ && !done)
        else $error("data read did not enter read state");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> done && state_reg == ST_IDLE)
        else $error("data read result missing");

    a_fill_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL && cnt_reg == 17'd1 |=> state_reg == ST_IDLE && !fill_armed_reg)
        else $error("fill did not finish cleanly");

    a_no_result_in_dma: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_CPRD) && $past(busy) |-> !done)
        else $error("result strobe during memory sweep");

endmodule

// ===== verif/vpae_checker.sv =====
`timescale 1ns / 100ps
// Checker for the video port access engine: predicts rdata per transaction and compares.
module vpae_checker
    import vpae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [15:0] word_in,
    input  logic        done,
    input  logic [15:0] rdata,
    output int          fail_count,
    output int          pending_reads
);

    logic [7:0]  vram [0:65535];
    logic [8:0]  cram [0:63];
    logic [15:0] vsram [0:63];
    logic [7:0]  regs [0:31];
    logic [15:0] addr;
    logic [1:0]  addr_hi;
    logic [5:0]  code;
    logic        pend;
    logic        fill_on;
    logic [9:0]  stat;
    logic [15:0] words_due [$];
    int          fails = 0;

    assign fail_count = fails;

    function automatic int unsigned xfer_len();
        int unsigned n;
        n = {regs[REG_LEN_HI], regs[REG_LEN_LO]};
        return (n == 0) ? 32'h10000 : n;
    endfunction

    task automatic bump_addr();
        addr = addr + 16'(regs[REG_INCR]);
    endtask

    task automatic clear_model();
        for (int i = 0; i < 65536; i++) vram[16'(i)] = '0;
        for (int i = 0; i < 64; i++)
        begin
            cram[6'(i)] = '0;
            vsram[6'(i)] = '0;
        end
        for (int i = 0; i < 32; i++) regs[5'(i)] = '0;
        addr = '0;
        addr_hi = '0;
        code = '0;
        pend = 1'b0;
        fill_on = 1'b0;
        stat = '0;
        words_due.delete();
    endtask

    task automatic apply_ctrl(input logic [15:0] w);
        int unsigned n;
        logic [15:0] src;
        if (!pend)
        begin
            if (w[15:14] == CTRL_REG_WRITE)
                regs[w[12:8]] = w[7:0];
            else
                pend = 1'b1;
            addr = {addr_hi, w[13:0]};
            code = {code[5:2], w[15:14]};
        end
        else
        begin
            pend = 1'b0;
            addr = {w[1:0], addr[13:0]};
            code = {w[7:4], code[1:0]};
            addr_hi = addr[15:14];
            if (code[5] && regs[REG_MODE2][4])
            begin
                if (regs[REG_DMA][7:6] == DMA_MODE_FILL)
                    fill_on = 1'b1;
                else if (regs[REG_DMA][7:6] == DMA_MODE_COPY)
                begin
                    n = xfer_len();
                    src = {regs[REG_SRC_HI], regs[REG_SRC_LO]};
                    repeat (n)
                    begin
                        vram[addr] = vram[src];
                        src = src + 16'd1;
                        bump_addr();
                    end
                    regs[REG_LEN_LO] = '0;
                    regs[REG_LEN_HI] = '0;
                end
            end
        end
    endtask

    task automatic apply_dwrite(input logic [15:0] w);
        logic [15:0] a;
        int unsigned n;
        pend = 1'b0;
        case (code[3:0])
            CODE_VRAM_WR:
            begin
                if (addr[0])
                    w = {w[7:0], w[15:8]};
                a = {addr[15:1], 1'b0};
                vram[a] = w[15:8];
                vram[a + 16'd1] = w[7:0];
            end
            CODE_CRAM_WR:
            begin
                w = w & 16'h0EEE;
                cram[addr[6:1]] = {w[3:1], w[7:5], w[11:9]};
            end
            CODE_VSRAM_WR: vsram[addr[6:1]] = w;
            default: ;
        endcase
        bump_addr();
        if (fill_on)
        begin
            n = xfer_len();
            repeat (n)
            begin
                vram[addr] = w[15:8];
                bump_addr();
            end
            fill_on = 1'b0;
        end
    endtask

    function automatic logic [15:0] fetch_word();
        logic [15:0] a;
        logic [8:0]  p;
        logic [15:0] r;
        r = '0;
        case (code[3:0])
            CODE_VRAM_RD:
            begin
                a = {addr[15:1], 1'b0};
                r = {vram[a], vram[a + 16'd1]};
            end
            CODE_CRAM_RD:
            begin
                p = cram[addr[6:1]];
                r = {4'd0, p[2:0], 1'b0, p[5:3], 1'b0, p[8:6], 1'b0};
            end
            CODE_VSRAM_RD: r = vsram[addr[6:1]];
            default: ;
        endcase
        return r;
    endfunction

    task automatic predict_transaction(input logic [1:0] o, input logic [15:0] w);
        logic [15:0] r;
        r = '0;
        case (o)
            OP_CTRL: apply_ctrl(w);
            OP_STAT:
            begin
                pend = 1'b0;
                stat = ((stat & ~10'h020) | 10'h200) ^ 10'h004;
                r = STATUS_FIXED | {6'd0, stat & STATUS_MASK};
            end
            OP_DWR: apply_dwrite(w);
            default:
            begin
                pend = 1'b0;
                r = fetch_word();
                bump_addr();
            end
        endcase
        words_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        fails = fails + 1;
    endtask

    // Results are compared before the same edge's transaction is predicted.
    always @(posedge clk)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (done)
            begin
                if (words_due.size() == 0)
                    report_mismatch("unexpected rdata", rdata, 16'h0);
                else if (rdata !== words_due[0])
                    report_mismatch("rdata", rdata, words_due.pop_front());
                else
                    void'(words_due.pop_front());
            end
            if (start && !busy)
                predict_transaction(op, word_in);
        end
        pending_reads = words_due.size();
    end

endmodule

// ===== verif/tb_video_port_access_engine.sv =====
`timescale 1ns / 100ps
// Top of the video port access engine regression: stimulus, reset and verdict.
module tb_video_port_access_engine
    import vpae_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [15:0] word_in;
    logic        done;
    logic [15:0] rdata;
    int          fail_count;
    int          pending_reads;
    int          idle_pct;
    longint      cycle_count = 0;

    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    video_port_access_engine dut (.*);

    vpae_checker checker_i (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("video_port_access_engine regression: fail");
            $finish;
        end
    end

    // Drives one transaction and returns once busy is seen low; it leaves start high.
    task automatic send(input logic [1:0] o, input logic [15:0] w);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        word_in <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic set_reg(input logic [4:0] r, input logic [7:0] v);
        send(OP_CTRL, {CTRL_REG_WRITE, 1'b0, r, v});
    endtask

    // Two-word address/code set-up; code bits 5..0, address 16 bits.
    task automatic setup_access(input logic [5:0] c, input logic [15:0] a);
        send(OP_CTRL, {c[1:0], a[13:0]});
        send(OP_CTRL, {8'd0, c[5:2], 2'd0, a[15:14]});
    endtask

    function automatic logic [5:0] pick_code();
        case ($urandom_range(7))
            0: return {2'b00, CODE_VRAM_RD};
            1: return {2'b00, CODE_VRAM_WR};
            2: return {2'b00, CODE_CRAM_WR};
            3: return {2'b00, CODE_CRAM_RD};
            4: return {2'b00, CODE_VSRAM_WR};
            5: return {2'b00, CODE_VSRAM_RD};
            default: return 6'($urandom_range(63)) & 6'h1F;
        endcase
    endfunction

    // Short DMA: small lengths (1 to 24), random source and DMA mode.
    task automatic dma_burst();
        logic [7:0] len;
        len = 8'($urandom_range(1, 24));
        set_reg(REG_MODE2, $urandom_range(1) ? 8'h10 : 8'h00);
        set_reg(REG_LEN_LO, len);
        set_reg(REG_LEN_HI, 8'h00);
        set_reg(REG_SRC_LO, 8'($urandom));
        set_reg(REG_SRC_HI, 8'($urandom));
        case ($urandom_range(3))
            0: set_reg(REG_DMA, 8'h80 | 8'($urandom_range(63)));
            1: set_reg(REG_DMA, 8'hC0 | 8'($urandom_range(63)));
            2: set_reg(REG_DMA, 8'h40);
            default: set_reg(REG_DMA, 8'h00);
        endcase
        setup_access({1'b1, $urandom_range(1) ? 1'b1 : 1'b0, 4'(CODE_VRAM_WR)},
                     16'($urandom));
        send(OP_DWR, 16'($urandom));
        send(OP_STAT, 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_CTRL;
        word_in = '0;
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: registers, every target, status, unknown codes, extremes.
        set_reg(REG_INCR, 8'd2);
        send(OP_STAT, 16'hFFFF);
        send(OP_STAT, 16'h0000);
        setup_access({2'b00, CODE_VRAM_WR}, 16'hFFFE);
        send(OP_DWR, 16'hFFFF);
        send(OP_DWR, 16'h1234);
        setup_access({2'b00, CODE_VRAM_RD}, 16'hFFFE);
        send(OP_DRD, 16'h0000);
        send(OP_DRD, 16'h0000);
        setup_access({2'b00, CODE_VRAM_WR}, 16'h0101);
        send(OP_DWR, 16'hABCD);
        setup_access({2'b00, CODE_CRAM_WR}, 16'h007E);
        send(OP_DWR, 16'hFFFF);
        setup_access({2'b00, CODE_CRAM_RD}, 16'h007E);
        send(OP_DRD, 16'h0000);
        setup_access({2'b00, CODE_VSRAM_WR}, 16'h0000);
        send(OP_DWR, 16'hFFFF);
        setup_access({2'b00, CODE_VSRAM_RD}, 16'h0000);
        send(OP_DRD, 16'h0000);
        setup_access(6'h3F, 16'hFFFF);
        send(OP_DWR, 16'h5555);
        send(OP_DRD, 16'h0000);
        send(OP_CTRL, 16'h4000);
        send(OP_STAT, 16'h0000);
        set_reg(REG_INCR, 8'hFF);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 64 : (ph == 3) ? 24 : 0;
            for (int i = 0; i < 340; i++)
            begin
                case ($urandom_range(9))
                    0: set_reg(5'($urandom), 8'($urandom));
                    1: set_reg(REG_INCR, 8'($urandom_range(3)));
                    2: setup_access(pick_code(), 16'($urandom));
                    3: send(OP_CTRL, 16'($urandom));
                    4: send(OP_STAT, 16'($urandom));
                    5, 6: send(OP_DWR, 16'($urandom));
                    7, 8: send(OP_DRD, 16'($urandom));
                    default: if ($urandom_range(3) == 0) dma_burst();
                endcase
            end
        end

        start <= 1'b0;
        while (pending_reads != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("video_port_access_engine regression: pass");
        else
            $display("video_port_access_engine regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/vpae_pkg.sv
design/video_port_access_engine.sv
verif/vpae_checker.sv
verif/tb_video_port_access_engine.sv
